@@ hw/rtl/rv32i_instruction_decoder_macros.svh @@
// Assertion macros shared by the decoder checker.
`ifndef RV32I_INSTRUCTION_DECODER_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RV32D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A stalled transfer keeps valid high and its payload unchanged.
`define RV32D_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

@@ hw/rtl/rv32d_pkg.sv @@
// Types and constants of the RV32I instruction decoder.
package rv32d_pkg;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_IMM_32 = 7'h1B;
  localparam logic [6:0] OPC_OP_32  = 7'h3B;

  localparam logic [6:0]  F7_BASE = 7'h00;
  localparam logic [6:0]  F7_ALT  = 7'h20;
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef enum logic [5:0] {
    KIND_ADD, KIND_SUB, KIND_SLL, KIND_SLT, KIND_SLTU, KIND_XOR, KIND_SRL, KIND_SRA,
    KIND_OR, KIND_AND, KIND_ADDI, KIND_SLTI, KIND_SLTIU, KIND_XORI, KIND_ORI,
    KIND_ANDI, KIND_SLLI, KIND_SRLI, KIND_SRAI, KIND_LB, KIND_LH, KIND_LW, KIND_LBU,
    KIND_LHU, KIND_SB, KIND_SH, KIND_SW, KIND_BEQ, KIND_BNE, KIND_BLT, KIND_BGE,
    KIND_BLTU, KIND_BGEU, KIND_JAL, KIND_JALR, KIND_LUI, KIND_AUIPC, KIND_FENCE,
    KIND_ECALL, KIND_EBREAK, KIND_INVALID
  } kind_e;

  typedef enum logic [2:0] {
    FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_INVALID
  } fmt_e;

  typedef enum logic [2:0] {
    ST_LEGAL, ST_BAD_LENGTH, ST_BAD_OPCODE, ST_BAD_FUNCT3, ST_BAD_FUNCT7,
    ST_BAD_SYSTEM, ST_EXTENSION
  } status_e;

  typedef struct packed {
    logic [31:0] instr_word;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         instr_kind;
    logic [2:0]         enc_format;
    logic [2:0]         decode_status;
    logic               is_legal;
    logic [6:0]         opcode_field;
    logic [4:0]         rd_index;
    logic [2:0]         funct3_field;
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic [6:0]         funct7_field;
    logic [11:0]        imm12_field;
    logic signed [31:0] immediate_value;
  } out_item_t;

endpackage

@@ hw/rtl/rv32d_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
interface rv32d_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/rv32i_instruction_decoder.sv @@
// RV32I instruction decoder: raw fields, identity, format, status, immediate.
//
//   channel | dir | payload      | handshake
//   in_i    | in  | in_item_t    | valid/ready
//   out_o   | out | out_item_t   | valid/ready
//
// Two register stages: the word is captured in word_q, decoded by combinational
// logic and the result is registered in out_q, which drives out_o.
// One word is taken every cycle while out_o is drained.
// Stalls on out_o fill both stages before in_i deasserts ready.
// Reset clears the stage valid bits only.
module rv32i_instruction_decoder
  import rv32d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rv32d_stream_if.sink          in_i,
  rv32d_stream_if.source        out_o
);

  logic        word_vld_q;
  logic [31:0] word_q;
  logic        out_vld_q;
  out_item_t   out_q;
  out_item_t   out_d;
  logic        out_ready;
  logic        word_ready;

  assign out_ready  = !out_vld_q || out_o.ready;
  assign word_ready = !word_vld_q || out_ready;
  assign in_i.ready = word_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (word_ready) begin
        word_vld_q <= in_i.valid;
      end
      if (out_ready) begin
        out_vld_q <= word_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_ready && in_i.valid) begin
      word_q <= in_i.payload.instr_word;
    end
    if (out_ready && word_vld_q) begin
      out_q <= out_d;
    end
  end

  // Decode
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  kind_e       kind;
  fmt_e        fmt;
  status_e     status;
  logic [31:0] imm;

  assign op = word_q[6:0];
  assign f3 = word_q[14:12];
  assign f7 = word_q[31:25];

  assign imm_i = {{20{word_q[31]}}, word_q[31:20]};
  assign imm_s = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
  assign imm_b = {{19{word_q[31]}}, word_q[31], word_q[7], word_q[30:25],
                  word_q[11:8], 1'b0};
  assign imm_u = {word_q[31:12], 12'h000};
  assign imm_j = {{11{word_q[31]}}, word_q[31], word_q[19:12], word_q[20],
                  word_q[30:21], 1'b0};

  always_comb begin
    kind   = KIND_INVALID;
    fmt    = FMT_INVALID;
    status = ST_LEGAL;
    imm    = 32'h0;
    if (word_q[1:0] != 2'b11) begin
      status = ST_BAD_LENGTH;
    end else begin
      unique case (op)
        OPC_LUI: begin
          kind = KIND_LUI; fmt = FMT_U; imm = imm_u;
        end
        OPC_AUIPC: begin
          kind = KIND_AUIPC; fmt = FMT_U; imm = imm_u;
        end
        OPC_JAL: begin
          kind = KIND_JAL; fmt = FMT_J; imm = imm_j;
        end
        OPC_JALR: begin
          if (f3 == 3'd0) begin
            kind = KIND_JALR; fmt = FMT_I; imm = imm_i;
          end else begin
            status = ST_BAD_FUNCT3;
          end
        end
        OPC_BRANCH: begin
          fmt = FMT_B; imm = imm_b;
          unique case (f3)
            3'd0:    kind = KIND_BEQ;
            3'd1:    kind = KIND_BNE;
            3'd4:    kind = KIND_BLT;
            3'd5:    kind = KIND_BGE;
            3'd6:    kind = KIND_BLTU;
            3'd7:    kind = KIND_BGEU;
            default: status = ST_BAD_FUNCT3;
          endcase
        end
        OPC_LOAD: begin
          fmt = FMT_I; imm = imm_i;
          unique case (f3)
            3'd0:    kind = KIND_LB;
            3'd1:    kind = KIND_LH;
            3'd2:    kind = KIND_LW;
            3'd4:    kind = KIND_LBU;
            3'd5:    kind = KIND_LHU;
            default: status = ST_BAD_FUNCT3;
          endcase
        end
        OPC_STORE: begin
          fmt = FMT_S; imm = imm_s;
          unique case (f3)
            3'd0:    kind = KIND_SB;
            3'd1:    kind = KIND_SH;
            3'd2:    kind = KIND_SW;
            default: status = ST_BAD_FUNCT3;
          endcase
        end
        OPC_OP_IMM: begin
          fmt = FMT_I; imm = imm_i;
          unique case (f3)
            3'd0: kind = KIND_ADDI;
            3'd1: begin
              if (f7 == F7_BASE) kind = KIND_SLLI;
              else               status = ST_BAD_FUNCT7;
            end
            3'd2: kind = KIND_SLTI;
            3'd3: kind = KIND_SLTIU;
            3'd4: kind = KIND_XORI;
            3'd5: begin
              if (f7 == F7_BASE)     kind = KIND_SRLI;
              else if (f7 == F7_ALT) kind = KIND_SRAI;
              else                   status = ST_BAD_FUNCT7;
            end
            3'd6: kind = KIND_ORI;
            default: kind = KIND_ANDI;
          endcase
        end
        OPC_OP: begin
          fmt = FMT_R;
          if (f7 == F7_BASE) begin
            unique case (f3)
              3'd0: kind = KIND_ADD;
              3'd1: kind = KIND_SLL;
              3'd2: kind = KIND_SLT;
              3'd3: kind = KIND_SLTU;
              3'd4: kind = KIND_XOR;
              3'd5: kind = KIND_SRL;
              3'd6: kind = KIND_OR;
              default: kind = KIND_AND;
            endcase
          end else if (f7 == F7_ALT && f3 == 3'd0) begin
            kind = KIND_SUB;
          end else if (f7 == F7_ALT && f3 == 3'd5) begin
            kind = KIND_SRA;
          end else begin
            status = ST_BAD_FUNCT7;
          end
        end
        OPC_FENCE: begin
          if (f3 == 3'd0) begin
            kind = KIND_FENCE; fmt = FMT_I; imm = imm_i;
          end else begin
            status = ST_EXTENSION;
          end
        end
        OPC_SYSTEM: begin
          fmt = FMT_I;
          if (f3 != 3'd0) begin
            status = ST_EXTENSION;
          end else if (word_q == WORD_ECALL) begin
            kind = KIND_ECALL;
          end else if (word_q == WORD_EBREAK) begin
            kind = KIND_EBREAK; imm = 32'h1;
          end else begin
            status = ST_BAD_SYSTEM;
          end
        end
        OPC_IMM_32, OPC_OP_32: status = ST_EXTENSION;
        default: status = ST_BAD_OPCODE;
      endcase
    end
    // a rejected word reports no identity, format or immediate
    if (status != ST_LEGAL) begin
      kind = KIND_INVALID;
      fmt  = FMT_INVALID;
      imm  = 32'h0;
    end
  end

  always_comb begin
    out_d.instr_kind      = kind;
    out_d.enc_format      = fmt;
    out_d.decode_status   = status;
    out_d.is_legal        = (status == ST_LEGAL);
    out_d.opcode_field    = op;
    out_d.rd_index        = word_q[11:7];
    out_d.funct3_field    = f3;
    out_d.rs1_index       = word_q[19:15];
    out_d.rs2_index       = word_q[24:20];
    out_d.funct7_field    = f7;
    out_d.imm12_field     = word_q[31:20];
    out_d.immediate_value = imm;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

@@ hw/rtl/rv32d_checker.sv @@
// Port-level assertions for the decoder, bound into rv32i_instruction_decoder.
`include "rv32i_instruction_decoder_macros.svh"

module rv32d_checker
  import rv32d_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  `RV32D_ASSERT(a_legal_flag, out_valid_i |-> (out_item_i.is_legal == (out_item_i.decode_status == ST_LEGAL)), "is_legal disagrees with decode_status")
  `RV32D_ASSERT(a_illegal_blank, (out_valid_i && !out_item_i.is_legal) |-> (out_item_i.instr_kind == KIND_INVALID && out_item_i.enc_format == FMT_INVALID && out_item_i.immediate_value == 32'sd0), "rejected word carries a decode")
  `RV32D_ASSERT(a_legal_kind, (out_valid_i && out_item_i.is_legal) |-> (out_item_i.instr_kind != KIND_INVALID && out_item_i.enc_format != FMT_INVALID), "legal word has no identity")
  `RV32D_ASSERT(a_raw_fields, out_valid_i |-> (out_item_i.imm12_field == {out_item_i.funct7_field, out_item_i.rs2_index}), "raw fields disagree")
  `RV32D_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_item_i, "stalled result changed")

endmodule

bind rv32i_instruction_decoder rv32d_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
